### rtl/battery_level_reporter_core_defines.svh
// Assertion helpers used by the RTL core.
`ifndef BATTERY_LEVEL_REPORTER_CORE_DEFINES_SVH
`define BATTERY_LEVEL_REPORTER_CORE_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define BLR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define BLR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/blr_pkg.sv
package blr_pkg;

    localparam int SAMPLES_PER_MEASURE = 16;
    localparam int IDX_W      = (SAMPLES_PER_MEASURE > 1) ? $clog2(SAMPLES_PER_MEASURE) : 1;
    localparam int SAMPLE_W   = 12;
    localparam int SUM_W      = SAMPLE_W + IDX_W;
    // compare width: holds 2*sum and N*voltage
    localparam int CMP_W      = SUM_W + 2;
    localparam int LEVEL_W    = 7;
    localparam int NUM_W      = CMP_W + LEVEL_W;
    localparam int DIV_CNT_W  = $clog2(LEVEL_W);
    localparam int VOLT_W     = 13;
    localparam int INTERVAL_W = 20;
    localparam int DATA_W     = 32;
    localparam int ADDR_W     = 4;
    localparam int REG_IDX_W  = 2;

    localparam logic [LEVEL_W-1:0] LEVEL_FULL  = 7'd100;
    localparam logic [LEVEL_W-1:0] LEVEL_EMPTY = 7'd0;

    localparam logic [VOLT_W-1:0]     FULL_RESET     = 13'd4200;
    localparam logic [VOLT_W-1:0]     EMPTY_RESET    = 13'd3300;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 20'd60000;

    localparam logic [REG_IDX_W-1:0] REG_FULL     = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_EMPTY    = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_INTERVAL = 2'd2;

    localparam logic REQ_TICK   = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic               done;
        logic [LEVEL_W-1:0] quot;
    } t_div_stat;

endpackage

### rtl/blr_div.sv
module blr_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [blr_pkg::NUM_W-1:0] i_num,
    input  logic [blr_pkg::CMP_W-1:0] i_den,
    output blr_pkg::t_div_stat        o_stat
);
    import blr_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0]     r_rem;
    logic [NUM_W-1:0]     r_dsh;
    logic [LEVEL_W-1:0]   r_q;
    logic                 w_fit;

    // restoring division, one quotient bit per cycle, MSB first
    assign w_fit = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(LEVEL_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_dsh <= NUM_W'(i_den) << (LEVEL_W - 1);
            r_q   <= '0;
        end else if (r_busy) begin
            if (w_fit) begin
                r_rem <= r_rem - r_dsh;
            end
            r_dsh <= r_dsh >> 1;
            r_q   <= {r_q[LEVEL_W-2:0], w_fit};
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.quot = r_q;

endmodule

### rtl/battery_level_reporter_core.sv
// Battery level reporter. Items arrive as millisecond ticks or ADC samples;
// a tick or a sample that does not close a measurement does not stall the input.
// The sample that closes a measurement (the sixteenth) leads to a setup
// state, then, unless the level clamps to 0 or 100, through the restoring
// divider (seven quotient bits, MSB first, then a done flag), and then to a
// done state that compares with the stored level and loads the output
// register. The input is stalled for that whole sequence, and also while a
// changed level waits for a full output register to drain. Registers sit at
// byte addresses 0 (full mV), 4 (empty mV) and 8 (report interval in ticks).
`include "battery_level_reporter_core_defines.svh"

module battery_level_reporter_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_req_type,
    input  logic [blr_pkg::SAMPLE_W-1:0] i_sample_mv,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [blr_pkg::LEVEL_W-1:0]  o_level_percent,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [blr_pkg::ADDR_W-1:0]   paddr,
    input  logic [blr_pkg::DATA_W-1:0]   pwdata,
    output logic [blr_pkg::DATA_W-1:0]   prdata,
    output logic                         pready
);
    import blr_pkg::*;

    t_state                r_state;
    t_state                n_state;
    logic [VOLT_W-1:0]     r_full;
    logic [VOLT_W-1:0]     r_empty;
    logic [INTERVAL_W-1:0] r_interval;
    logic [INTERVAL_W-1:0] r_tick;
    logic                  r_measuring;
    logic [IDX_W-1:0]      r_idx;
    logic [SUM_W-1:0]      r_sum;
    logic [LEVEL_W-1:0]    r_level;
    logic [LEVEL_W-1:0]    r_last_level;
    logic                  r_level_known;
    logic                  r_out_valid;
    logic [LEVEL_W-1:0]    r_out_level;

    logic                  w_cfg_wr;
    logic [REG_IDX_W-1:0]  w_reg_idx;
    logic                  w_in_acc;
    logic                  w_last_sample;
    logic [INTERVAL_W:0]   w_tick_next;
    logic                  w_tick_wrap;
    logic [CMP_W-1:0]      w_v2;
    logic [CMP_W-1:0]      w_hi;
    logic [CMP_W-1:0]      w_lo;
    logic [CMP_W-1:0]      w_den;
    logic [NUM_W-1:0]      w_num;
    logic                  w_at_full;
    logic                  w_clamp;
    logic                  w_emit;
    logic                  w_out_free;
    logic                  w_div_start;
    logic                  w_out_load;
    logic                  w_finish;
    t_div_stat             w_div;

    // configuration port
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[ADDR_W-1:2];
    assign w_cfg_wr  = psel && penable && pwrite;

    always_comb begin
        case (w_reg_idx)
            REG_FULL:     prdata = DATA_W'(r_full);
            REG_EMPTY:    prdata = DATA_W'(r_empty);
            REG_INTERVAL: prdata = DATA_W'(r_interval);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full     <= FULL_RESET;
            r_empty    <= EMPTY_RESET;
            r_interval <= INTERVAL_RESET;
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                REG_FULL:     r_full     <= pwdata[VOLT_W-1:0];
                REG_EMPTY:    r_empty    <= pwdata[VOLT_W-1:0];
                REG_INTERVAL: r_interval <= pwdata[INTERVAL_W-1:0];
                default:      ;
            endcase
        end
    end

    // datapath terms
    assign w_in_acc      = i_in_valid && (r_state == ST_IDLE);
    assign w_last_sample = (r_idx == IDX_W'(SAMPLES_PER_MEASURE - 1));
    assign w_tick_next   = {1'b0, r_tick} + 1'b1;
    assign w_tick_wrap   = (w_tick_next >= {1'b0, r_interval});

    assign w_v2      = CMP_W'({r_sum, 1'b0});
    assign w_hi      = CMP_W'(r_full * SAMPLES_PER_MEASURE);
    assign w_lo      = CMP_W'(r_empty * SAMPLES_PER_MEASURE);
    assign w_den     = w_hi - w_lo;
    assign w_num     = NUM_W'(w_v2 - w_lo) * NUM_W'(LEVEL_FULL);
    assign w_at_full = (w_v2 >= w_hi);
    // full test first, so the divisor is nonzero whenever the divider runs
    assign w_clamp   = w_at_full || (w_v2 <= w_lo);

    assign w_emit     = r_level_known && (r_level != r_last_level);
    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (w_in_acc && (i_req_type == REQ_SAMPLE) && r_measuring && w_last_sample) begin
                    n_state = ST_PREP;
                end
            end
            ST_PREP: begin
                n_state = w_clamp ? ST_DONE : ST_DIV;
            end
            ST_DIV: begin
                if (w_div.done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!w_emit || w_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_stall  = (r_state != ST_IDLE);
        w_div_start = (r_state == ST_PREP) && !w_clamp;
        w_finish    = (r_state == ST_DONE) && (!w_emit || w_out_free);
        w_out_load  = (r_state == ST_DONE) && w_emit && w_out_free;
    end

    blr_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_stat  (w_div)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_tick        <= '0;
            r_measuring   <= 1'b1;
            r_idx         <= '0;
            r_sum         <= '0;
            r_last_level  <= '0;
            r_level_known <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_in_acc) begin
                if (i_req_type == REQ_TICK) begin
                    if (w_tick_wrap) begin
                        r_tick <= '0;
                        if (!r_measuring) begin
                            r_measuring <= 1'b1;
                            r_idx       <= '0;
                            r_sum       <= '0;
                        end
                    end else begin
                        r_tick <= w_tick_next[INTERVAL_W-1:0];
                    end
                end else if (r_measuring) begin
                    r_sum <= r_sum + SUM_W'(i_sample_mv);
                    if (w_last_sample) begin
                        r_measuring <= 1'b0;
                        r_idx       <= '0;
                    end else begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
            end
            if (w_finish) begin
                r_level_known <= 1'b1;
                r_last_level  <= r_level;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_PREP) begin
            r_level <= w_at_full ? LEVEL_FULL : LEVEL_EMPTY;
        end else if ((r_state == ST_DIV) && w_div.done) begin
            r_level <= w_div.quot;
        end
        if (w_out_load) begin
            r_out_level <= r_level;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_level_percent = r_out_level;

    `BLR_ASSERT_NOW(a_div_done_in_div, w_div.done, r_state == ST_DIV, "divider finished outside its state")
    `BLR_ASSERT_NOW(a_level_range, r_out_valid, r_out_level <= LEVEL_FULL, "level above 100 percent")
    `BLR_ASSERT_NEXT(a_emit_tracks_last, w_out_load, r_out_level == r_last_level && r_out_valid, "emitted level not stored")

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import blr_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 16;
    localparam int REPORT_MAX = 10;

    // Predicts the change-only battery level stream and checks the DUT against it.
    class gauge_scoreboard;
        bit [VOLT_W-1:0]     full_mv;
        bit [VOLT_W-1:0]     empty_mv;
        bit [INTERVAL_W-1:0] interval;
        int unsigned         tick_count;
        bit                  measuring;
        int unsigned         sample_index;
        int unsigned         sample_sum;
        bit [LEVEL_W-1:0]    last_level;
        bit                  level_known;
        bit [LEVEL_W-1:0]    pending_levels[$];
        int errors, items, ticks, measurements, changes;

        function new();
            full_mv      = FULL_RESET;
            empty_mv     = EMPTY_RESET;
            interval     = INTERVAL_RESET;
            tick_count   = 0;
            measuring    = 1'b1;
            sample_index = 0;
            sample_sum   = 0;
            last_level   = '0;
            level_known  = 1'b0;
        endfunction

        function void flag(string what, int expected_val, int actual_val);
            errors++;
            if (errors <= REPORT_MAX)
                $display("[%0t] %s: expected %0d, got %0d", $time, what, expected_val,
                         actual_val);
        endfunction

        function void set_reg(logic [REG_IDX_W-1:0] idx, logic [DATA_W-1:0] value);
            case (idx)
                REG_FULL:     full_mv = value[VOLT_W-1:0];
                REG_EMPTY:    empty_mv = value[VOLT_W-1:0];
                REG_INTERVAL: interval = value[INTERVAL_W-1:0];
                default: ;
            endcase
        endfunction

        // 2*sum against N*full / N*empty; full tested first so the divisor stays positive
        function int unsigned level_of_sum(int unsigned sum);
            int unsigned v2, top, bottom;
            v2     = 2 * sum;
            top    = SAMPLES_PER_MEASURE * full_mv;
            bottom = SAMPLES_PER_MEASURE * empty_mv;
            if (v2 >= top)
                return LEVEL_FULL;
            if (v2 <= bottom)
                return LEVEL_EMPTY;
            return ((v2 - bottom) * 100) / (top - bottom);
        endfunction

        function void note_item(logic kind, logic [SAMPLE_W-1:0] mv);
            int unsigned level;
            items++;
            if (kind == REQ_TICK) begin
                ticks++;
                if (tick_count + 1 >= interval) begin
                    tick_count = 0;
                    if (!measuring) begin
                        measuring    = 1'b1;
                        sample_index = 0;
                        sample_sum   = 0;
                    end
                end else begin
                    tick_count = (tick_count + 1) & ((1 << INTERVAL_W) - 1);
                end
                return;
            end
            if (!measuring)
                return;
            sample_sum += mv;
            sample_index++;
            if (sample_index < SAMPLES_PER_MEASURE)
                return;
            level = level_of_sum(sample_sum);
            measurements++;
            measuring    = 1'b0;
            sample_index = 0;
            sample_sum   = 0;
            if (!level_known) begin
                level_known = 1'b1;
                last_level  = LEVEL_W'(level);
            end else if (LEVEL_W'(level) != last_level) begin
                last_level = LEVEL_W'(level);
                pending_levels.push_back(LEVEL_W'(level));
                changes++;
            end
        endfunction

        function void check_level(logic [LEVEL_W-1:0] got);
            bit [LEVEL_W-1:0] want;
            if (pending_levels.size() == 0) begin
                flag("level transfer with nothing pending", -1, got);
                return;
            end
            want = pending_levels.pop_front();
            if (got !== want)
                flag("level_percent", want, got);
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic                  i_req_type = REQ_TICK;
    logic [SAMPLE_W-1:0]   i_sample_mv = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [LEVEL_W-1:0]    o_level_percent;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [ADDR_W-1:0]     paddr = '0;
    logic [DATA_W-1:0]     pwdata = '0;
    logic [DATA_W-1:0]     prdata;
    logic                  pready;

    gauge_scoreboard sb;
    int  gap_odds = 0;
    int  stall_odds = 0;
    bit  long_hold = 1'b0;
    int  settings = 0;
    int  cycles = 0;

    battery_level_reporter_core u_dut (.*);

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk)
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_level(o_level_percent);

    // receiver: random stall bursts, plus one long hold-off on request
    initial begin
        int hold_count;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                i_out_stall <= 1'b1;
                hold_count = 0;
                while (hold_count < HOLD_CYCLES) begin
                    @(negedge i_clk);
                    hold_count++;
                end
                long_hold = 1'b0;
                i_out_stall <= 1'b0;
            end else if (stall_odds != 0 && $urandom_range(1, 100) <= stall_odds) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 13)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end
        end
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("DONE: errors detected");
        $finish;
    end

    // called at a falling edge; returns at the falling edge after the transfer
    task automatic send_item(input logic kind, input logic [SAMPLE_W-1:0] mv);
        if (gap_odds != 0 && $urandom_range(1, 100) <= gap_odds) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_req_type  <= kind;
        i_sample_mv <= mv;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_item(kind, mv);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input int value);
        logic [DATA_W-1:0] want;
        want = (idx == REG_INTERVAL) ? (value & ((1 << INTERVAL_W) - 1))
                                     : (value & ((1 << VOLT_W) - 1));
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, value);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want)
            sb.flag("register readback", want, prdata);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // the closing sample may still be in the divider with no level to show for it
    task automatic wait_idle();
        while (sb.pending_levels.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic run_setting(input int full, input int empty, input int interval,
                               input int count, input bit hold);
        int  lo, hi, target, mv;
        logic kind;
        wait_idle();
        write_reg(REG_FULL, full);
        write_reg(REG_EMPTY, empty);
        write_reg(REG_INTERVAL, interval);
        settings++;
        if (hold)
            long_hold = 1'b1;
        lo = ((full < empty) ? full : empty) - 200;
        hi = ((full > empty) ? full : empty) + 200;
        if (lo < 0) lo = 0;
        if (hi > 8190) hi = 8190;
        target = lo;
        repeat (count) begin
            if ($urandom_range(0, 99) < 8) begin
                // noise: anything, including samples nobody asked for
                kind = 1'($urandom_range(0, 1));
                mv   = $urandom_range(0, 4095);
            end else if (sb.measuring && $urandom_range(0, 9) != 0) begin
                if (sb.sample_index == 0)
                    target = $urandom_range(lo, hi);
                kind = REQ_SAMPLE;
                mv   = target / 2 + $urandom_range(0, 60) - 30;
                if (mv < 0) mv = 0;
                if (mv > 4095) mv = 4095;
            end else begin
                kind = REQ_TICK;
                mv   = $urandom_range(0, 4095);
            end
            send_item(kind, SAMPLE_W'(mv));
        end
        i_in_valid <= 1'b0;
    endtask

    initial begin
        int full, empty, swap, rounds;
        sb = new();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // measurement pending from reset: level is stored, never reported
        for (int k = 0; k < SAMPLES_PER_MEASURE; k++)
            send_item(REQ_SAMPLE, k[0] ? ~(SAMPLE_W'(k * 64)) : SAMPLE_W'(k * 64));
        send_item(REQ_SAMPLE, 12'hFFF);    // outside a measurement
        send_item(REQ_TICK, 12'h000);
        send_item(REQ_TICK, 12'hFFF);
        i_in_valid <= 1'b0;

        gap_odds   = 10;
        stall_odds = 10;
        run_setting(4200, 3300, 1, 150, 1'b0);
        gap_odds   = 0;
        stall_odds = 0;
        run_setting(8190, 0, 3, 150, 1'b1);     // long receiver hold-off here
        gap_odds   = 30;
        stall_odds = 30;
        run_setting(3000, 3500, 2, 80, 1'b0);   // full below empty
        run_setting(4000, 4000, 0, 80, 1'b0);   // equal limits, zero interval
        run_setting(0, 0, 5, 40, 1'b0);
        run_setting(8190, 8190, 1, 60, 1'b0);
        run_setting(4200, 3300, 1000000, 30, 1'b0);

        rounds = 0;
        while (sb.items < 1250 && rounds < 60) begin
            full  = $urandom_range(0, 8190);
            empty = $urandom_range(0, 8190);
            if (full < empty && $urandom_range(0, 4) != 0) begin
                swap  = full;
                full  = empty;
                empty = swap;
            end
            gap_odds   = $urandom_range(0, 3) * 10;
            stall_odds = $urandom_range(0, 3) * 10;
            run_setting(full, empty, $urandom_range(0, 8), $urandom_range(40, 150), 1'b0);
            rounds++;
        end

        gap_odds   = 0;
        stall_odds = 0;
        run_setting(4200, 3300, 2, 100, 1'b0);

        wait_idle();
        repeat (30) @(negedge i_clk);
        $display("Sent %0d items (%0d ticks) over %0d register settings;",
                 sb.items, sb.ticks, settings);
        $display("%0d measurements closed, %0d level changes checked.",
                 sb.measurements, sb.changes);
        if (sb.errors == 0 && sb.pending_levels.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

### sim.f
+incdir+rtl
rtl/blr_pkg.sv
rtl/blr_div.sv
rtl/battery_level_reporter_core.sv
tb/testbench.sv
